// ----- rtl/b2a_pkg.sv -----
`default_nettype none
package b2a_pkg;

    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned CHAR_W     = 7;
    localparam int unsigned DEC_DIGITS = 10;
    localparam int unsigned BCD_W      = DEC_DIGITS * 4;
    localparam int unsigned NUM_CHARS  = 10;

    localparam logic       FUNC_HEX  = 1'b0;
    localparam logic       FUNC_DEC  = 1'b1;
    localparam logic [6:0] CHAR_ZERO = 7'h30;
    localparam logic [6:0] CHAR_X    = 7'h78;

    typedef struct packed {
        logic                  func;
        logic [VALUE_W-1:0]    value;
    } t_in;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } t_out;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [CHAR_W-1:0] hex_glyph(input logic [3:0] nib);
        logic [CHAR_W-1:0] code;
        if (nib < 4'd10) begin
            code = CHAR_ZERO + {3'd0, nib};
        end else begin
            code = 7'h37 + {3'd0, nib};
        end
        return code;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/b2a_front.sv -----
`default_nettype none
module b2a_front
    import b2a_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_in     i_data,
    output logic         o_stall,
    input  wire t_q_stat i_q_stat,
    output logic         o_push,
    output t_in          o_cmd
);

    logic r_vld;
    logic n_vld;
    t_in  r_cmd;
    logic accept;

    assign o_stall = r_vld && i_q_stat.full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_vld && !i_q_stat.full;
    assign o_cmd   = r_cmd;

    always_comb begin
        n_vld = r_vld;
        if (accept) begin
            n_vld = 1'b1;
        end else if (o_push) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // The format select is a single bit; a one selects decimal and a zero selects hex.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.func  <= (i_data.func == FUNC_DEC) ? FUNC_DEC : FUNC_HEX;
            r_cmd.value <= i_data.value;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/b2a_queue.sv -----
`default_nettype none
module b2a_queue
    import b2a_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_in  i_cmd,
    input  wire logic i_pop,
    output t_q_stat   o_stat,
    output t_in       o_cmd
);

    t_in        r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);
    assign o_cmd        = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/b2a_back.sv -----
`default_nettype none
module b2a_back
    import b2a_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_q_stat i_q_stat,
    input  wire t_in     i_cmd,
    output logic         o_pop,
    output logic         o_valid,
    output t_out         o_data,
    input  wire logic    i_stall
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [VALUE_W-1:0] r_bin;
    logic [VALUE_W-1:0] n_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic [BCD_W-1:0]   n_bcd;
    logic [4:0]         r_cnt;
    logic [4:0]         n_cnt;
    logic [3:0]         r_idx;
    logic [3:0]         n_idx;
    logic               r_lead;
    logic               n_lead;
    logic               r_dec;
    logic               n_dec;
    logic               r_ovld;
    logic               n_ovld;
    t_out               r_out;
    t_out               n_out;

    logic               out_free;
    logic               is_last;
    logic [3:0]         dec_nib;
    logic [BCD_W-1:0]   bcd_adj;

    assign out_free = !r_ovld || !i_stall;
    assign o_pop    = (r_state == ST_IDLE) && !i_q_stat.empty;
    assign o_valid  = r_ovld;
    assign o_data   = r_out;
    assign is_last  = (r_idx == 4'(NUM_CHARS - 1));
    assign dec_nib  = r_bcd[BCD_W-1 -: 4];

    always_comb begin
        for (int k = 0; k < DEC_DIGITS; k++) begin
            if (r_bcd[k*4 +: 4] >= 4'd5) begin
                bcd_adj[k*4 +: 4] = r_bcd[k*4 +: 4] + 4'd3;
            end else begin
                bcd_adj[k*4 +: 4] = r_bcd[k*4 +: 4];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_lead  = r_lead;
        n_dec   = r_dec;
        n_ovld  = r_ovld;
        n_out   = r_out;
        if (out_free) begin
            n_ovld = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    n_bin   = i_cmd.value;
                    n_bcd   = '0;
                    n_cnt   = 5'd0;
                    n_idx   = 4'd0;
                    n_lead  = 1'b1;
                    n_dec   = i_cmd.func;
                    n_state = (i_cmd.func == FUNC_DEC) ? ST_CONV : ST_EMIT;
                end
            end
            ST_CONV: begin
                {n_bcd, n_bin} = {bcd_adj[BCD_W-2:0], r_bin, 1'b0};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(VALUE_W - 1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_idx = r_idx + 4'd1;
                    if (r_dec == FUNC_DEC) begin
                        n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
                        if (!(r_lead && dec_nib == 4'd0 && !is_last)) begin
                            n_lead          = 1'b0;
                            n_ovld          = 1'b1;
                            n_out.char_code = CHAR_ZERO + {3'd0, dec_nib};
                            n_out.last      = is_last;
                        end
                    end else begin
                        n_ovld     = 1'b1;
                        n_out.last = is_last;
                        if (r_idx == 4'd0) begin
                            n_out.char_code = CHAR_ZERO;
                        end else if (r_idx == 4'd1) begin
                            n_out.char_code = CHAR_X;
                        end else begin
                            n_out.char_code = hex_glyph(r_bin[VALUE_W-1 -: 4]);
                            n_bin           = {r_bin[VALUE_W-5:0], 4'd0};
                        end
                    end
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_cnt  <= n_cnt;
        r_idx  <= n_idx;
        r_lead <= n_lead;
        r_dec  <= n_dec;
        r_out  <= n_out;
    end

endmodule
`default_nettype wire

// ----- rtl/binary_to_ascii_hex_dec_formatter_top.sv -----
// An accepted item passes from the front register through the queue to the back end. In hex mode
// the back end goes straight to emitting characters; in decimal mode it first runs 32 shift-add
// steps in its converter, and leading zeros are suppressed as the digits are emitted.
// A single conversion and character unit finishes each item before it pops the next one;
// a two-entry queue buffers the front.
// Reset is synchronous and active low; it empties the queue and drops any pending beat.
`default_nettype none
module binary_to_ascii_hex_dec_formatter_top
    import b2a_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_in  i_data,
    output logic      o_stall,
    output logic      o_valid,
    output t_out      o_data,
    input  wire logic i_stall
);

    t_q_stat q_stat;
    logic    push;
    logic    pop;
    t_in     front_cmd;
    t_in     queue_cmd;

    b2a_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_data   (i_data),
        .o_stall  (o_stall),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    b2a_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_stat  (q_stat),
        .o_cmd   (queue_cmd)
    );

    b2a_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_cmd    (queue_cmd),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .o_data   (o_data),
        .i_stall  (i_stall)
    );

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("push into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from an empty queue");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("beat pending after reset");
`endif

endmodule
`default_nettype wire
